>>> design/gtp_pkg.sv
package gtp_pkg;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IDLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_SPACE     = 3'd1,
    PH_LEADMINUS = 3'd2,
    PH_SIGN      = 3'd3,
    PH_ZERO      = 3'd4,
    PH_ZEROX     = 3'd5,
    PH_DIGITS    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [2:0]  field_idx;
    phase_t      phase;
    logic [63:0] magnitude;
    logic        overflowed;
    logic        negative;
    logic [63:0] leading;
    logic [63:0] trailing;
  } state_t;

  localparam logic [2:0] FIELD_FIRST  = 3'd0;
  localparam logic [2:0] FIELD_SECOND = 3'd1;
  localparam logic [2:0] FIELD_THIRD  = 3'd2;
  localparam logic [2:0] FIELD_FOURTH = 3'd3;
  localparam logic [2:0] FIELD_LAST   = 3'd4;
  localparam logic [2:0] FIELD_IDLE   = 3'd7;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  localparam logic [15:0] CH_LBRACE  = 16'h007B;
  localparam logic [15:0] CH_RBRACE  = 16'h007D;
  localparam logic [15:0] CH_MINUS   = 16'h002D;
  localparam logic [15:0] CH_PLUS    = 16'h002B;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_TAB     = 16'h0009;
  localparam logic [15:0] CH_CR      = 16'h000D;
  localparam logic [15:0] CH_LOWER_X = 16'h0078;
  localparam logic [15:0] CH_UPPER_X = 16'h0058;
  localparam logic [15:0] CH_DIGIT0  = 16'h0030;
  localparam logic [15:0] CH_DIGIT9  = 16'h0039;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;
  localparam logic [15:0] CH_LOWER_F = 16'h0066;
  localparam logic [15:0] CH_UPPER_A = 16'h0041;
  localparam logic [15:0] CH_UPPER_F = 16'h0046;

  function automatic logic [4:0] hex_of(input logic [15:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
      d = 5'(c - CH_DIGIT0);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = 5'(c - CH_LOWER_A + 16'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = 5'(c - CH_UPPER_A + 16'd10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [15:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> design/gtp_step.sv
module gtp_step (
  input  gtp_pkg::state_t  state_i,
  input  logic             start_i,
  input  logic [15:0]      char_i,
  output gtp_pkg::state_t  state_nxt,
  output gtp_pkg::status_t status_nxt,
  output logic [63:0]      guid_high_nxt,
  output logic [63:0]      guid_low_nxt
);
  import gtp_pkg::*;

  function automatic state_t clear_field(input state_t s);
    state_t r;
    r = s;
    r.phase      = PH_START;
    r.magnitude  = '0;
    r.overflowed = 1'b0;
    r.negative   = 1'b0;
    return r;
  endfunction

  state_t      s;
  status_t     st;
  logic [4:0]  dig;
  logic        nd;
  logic        sp;
  logic        lim32;
  logic        first;
  logic        do_acc;
  logic        do_close;
  logic        do_fail;
  logic [63:0] v;
  logic [15:0] sep;

  assign dig = hex_of(char_i);
  assign nd  = dig[4];
  assign sp  = is_space(char_i);

  always_comb begin
    s        = state_i;
    st       = ST_BUSY;
    first    = 1'b0;
    do_acc   = 1'b0;
    do_close = 1'b0;
    do_fail  = 1'b0;
    v        = '0;
    lim32    = 1'b0;
    sep      = CH_MINUS;

    if (start_i) begin
      s.leading  = '0;
      s.trailing = '0;
      s = clear_field(s);
      if (char_i == CH_LBRACE) begin
        s.field_idx = FIELD_FIRST;
      end else begin
        do_fail = 1'b1;
      end
    end else if (s.field_idx > FIELD_LAST) begin
      s.field_idx = FIELD_IDLE;
      st = ST_IDLE;
    end else begin
      // a lone '-' was the separator of an empty field: close it as zero
      if (s.phase == PH_LEADMINUS && nd) begin
        if (s.field_idx == FIELD_LAST) begin
          do_fail = 1'b1;
        end else begin
          if (s.field_idx == FIELD_FIRST) s.leading = '0;
          if (s.field_idx == FIELD_FOURTH) s.trailing = '0;
          s.field_idx = s.field_idx + 3'd1;
          s = clear_field(s);
        end
      end
      if (!do_fail) begin
        case (s.phase)
          PH_START: begin
            if (sp) begin
              s.phase = PH_SPACE;
            end else if (char_i == CH_MINUS) begin
              s.negative = 1'b1;
              s.phase = PH_LEADMINUS;
            end else if (char_i == CH_PLUS) begin
              s.phase = PH_SIGN;
            end else begin
              first = 1'b1;
            end
          end
          PH_SPACE: begin
            if (sp) begin
              s.phase = PH_SPACE;
            end else if (char_i == CH_MINUS) begin
              s.negative = 1'b1;
              s.phase = PH_SIGN;
            end else if (char_i == CH_PLUS) begin
              s.phase = PH_SIGN;
            end else if (nd) begin
              do_fail = 1'b1;
            end else begin
              first = 1'b1;
            end
          end
          PH_LEADMINUS: first = 1'b1;
          PH_SIGN: begin
            if (nd) do_fail = 1'b1;
            else first = 1'b1;
          end
          PH_ZERO: begin
            if (char_i == CH_LOWER_X || char_i == CH_UPPER_X) begin
              s.phase = PH_ZEROX;
            end else if (nd) begin
              do_close = 1'b1;
            end else begin
              do_acc = 1'b1;
              s.phase = PH_DIGITS;
            end
          end
          PH_ZEROX: begin
            if (nd) begin
              do_fail = 1'b1;
            end else begin
              do_acc = 1'b1;
              s.phase = PH_DIGITS;
            end
          end
          PH_DIGITS: begin
            if (nd) do_close = 1'b1;
            else do_acc = 1'b1;
          end
          default: do_fail = 1'b1;
        endcase
        if (first) begin
          if (nd) begin
            do_close = 1'b1;
          end else if (dig == 5'd0) begin
            s.phase = PH_ZERO;
          end else begin
            do_acc = 1'b1;
            s.phase = PH_DIGITS;
          end
        end
      end
    end

    lim32 = (s.field_idx != FIELD_LAST);

    if (do_acc && !s.overflowed) begin
      if (lim32 ? (|s.magnitude[63:28]) : (|s.magnitude[63:60])) begin
        s.overflowed = 1'b1;
      end else begin
        s.magnitude = {s.magnitude[59:0], dig[3:0]};
      end
    end

    if (do_close) begin
      v = s.negative ? (64'd0 - s.magnitude) : s.magnitude;
      if (lim32) v[63:32] = '0;
      sep = lim32 ? CH_MINUS : CH_RBRACE;
      if (s.overflowed) begin
        do_fail = 1'b1;
      end else if (s.field_idx >= FIELD_SECOND && s.field_idx <= FIELD_FOURTH
                   && (|v[63:16])) begin
        do_fail = 1'b1;
      end else if (s.field_idx == FIELD_LAST && (|v[63:48])) begin
        do_fail = 1'b1;
      end else if (char_i != sep) begin
        do_fail = 1'b1;
      end else begin
        case (s.field_idx)
          FIELD_FIRST:  s.leading  = {v[31:0], 32'd0};
          FIELD_SECOND: s.leading  = s.leading | {32'd0, v[15:0], 16'd0};
          FIELD_THIRD:  s.leading  = s.leading | {48'd0, v[15:0]};
          FIELD_FOURTH: s.trailing = {v[15:0], 48'd0};
          default:      s.trailing = s.trailing | v;
        endcase
        if (s.field_idx == FIELD_LAST) begin
          st = ST_DONE;
          s.field_idx = FIELD_IDLE;
        end else begin
          s.field_idx = s.field_idx + 3'd1;
        end
        s = clear_field(s);
      end
    end

    if (do_fail) begin
      s.field_idx = FIELD_IDLE;
      s = clear_field(s);
      st = ST_ERR;
    end
  end

  assign state_nxt     = s;
  assign status_nxt    = st;
  assign guid_high_nxt = (st == ST_DONE) ? s.leading : 64'd0;
  assign guid_low_nxt  = (st == ST_DONE) ? s.trailing : 64'd0;

endmodule

>>> design/guid_text_parser.sv
// A character beat accepted at the input goes through the input register, then through the
// parse logic into the result register, which then holds its status beat.
// Throughput: one character per cycle while out_ready does not stall the result register.
// While a status beat waits on out_ready, the input register can still take one more beat.
// Reset (rst_n low, synchronous): both stages empty, parser idle with cleared fields.
module guid_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic [15:0] in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_guid_high,
  output logic [63:0] out_guid_low
);
  import gtp_pkg::*;

  logic        s1_valid_r;
  logic        s1_start_r;
  logic [15:0] s1_char_r;
  state_t      state_r;
  state_t      state_nxt;
  status_t     status_nxt;
  logic [63:0] guid_high_nxt;
  logic [63:0] guid_low_nxt;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [63:0] out_guid_high_r;
  logic [63:0] out_guid_low_r;
  logic        s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  gtp_step u_step (
    .state_i       (state_r),
    .start_i       (s1_start_r),
    .char_i        (s1_char_r),
    .state_nxt     (state_nxt),
    .status_nxt    (status_nxt),
    .guid_high_nxt (guid_high_nxt),
    .guid_low_nxt  (guid_low_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start_r <= in_start_req;
      s1_char_r  <= in_char_code;
    end
  end

  // advance parser state only when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.field_idx  <= FIELD_IDLE;
      state_r.phase      <= PH_START;
      state_r.magnitude  <= '0;
      state_r.overflowed <= 1'b0;
      state_r.negative   <= 1'b0;
      state_r.leading    <= '0;
      state_r.trailing   <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r    <= status_nxt;
      out_guid_high_r <= guid_high_nxt;
      out_guid_low_r  <= guid_low_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_guid_high = out_guid_high_r;
  assign out_guid_low  = out_guid_low_r;

  a_guid_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> (out_guid_high_r == 64'd0 &&
                                                  out_guid_low_r == 64'd0))
    else $error("guid nonzero on a beat that is not done");

  a_field_idx_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.field_idx <= FIELD_LAST || state_r.field_idx == FIELD_IDLE))
    else $error("field index outside parse range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !s1_adv) |=> $stable(state_r))
    else $error("parser state changed without a beat");

  a_err_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && status_nxt == ST_ERR) |=> (state_r.field_idx == FIELD_IDLE))
    else $error("parser not idle after error");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && status_nxt == ST_DONE) |=> (state_r.field_idx == FIELD_IDLE &&
                                           out_status_r == ST_DONE))
    else $error("parser not idle after done");

endmodule

>>> test/guid_text_parser_chk.sv
module guid_text_parser_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_start_req,
  input  logic [15:0] in_char_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [63:0] out_guid_high,
  input  logic [63:0] out_guid_low,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam logic [63:0] WORD_MAX  = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] NODE_MAX  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] NARROW_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    status_t     status;
    logic [63:0] high;
    logic [63:0] low;
  } guid_beat_t;

  guid_beat_t status_q[$];
  guid_beat_t want;

  // parser state as the predictor tracks it
  logic [2:0]  fld_idx;
  phase_t      phase;
  logic [63:0] mag;
  logic        ovf;
  logic        neg;
  logic [63:0] hi_acc;
  logic [63:0] lo_acc;

  function automatic logic is_blank(input logic [15:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [4:0] nibble_of(input logic [15:0] c);
    logic [15:0] folded;
    folded = c | 16'h0020;
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return {1'b0, c[3:0]};
    if (folded >= CH_LOWER_A && folded <= CH_LOWER_F) return {1'b0, c[3:0]} + 5'd9;
    return NO_DIGIT;
  endfunction

  function automatic void reset_field();
    phase = PH_START;
    mag   = '0;
    ovf   = 1'b0;
    neg   = 1'b0;
  endfunction

  function automatic status_t abort_parse();
    fld_idx = FIELD_IDLE;
    reset_field();
    return ST_ERR;
  endfunction

  function automatic logic [63:0] field_max();
    return (fld_idx < FIELD_LAST) ? NARROW_MAX : '1;
  endfunction

  function automatic void shift_in(input logic [3:0] d);
    if (ovf) return;
    if (mag > (field_max() >> 4)) ovf = 1'b1;
    else mag = {mag[59:0], d};
  endfunction

  function automatic status_t finish_field(input logic [15:0] c);
    logic [63:0] v;
    if (ovf) return abort_parse();
    v = (neg ? (64'd0 - mag) : mag) & field_max();
    if (fld_idx >= FIELD_SECOND && fld_idx <= FIELD_FOURTH && v > WORD_MAX) return abort_parse();
    if (fld_idx == FIELD_LAST && v > NODE_MAX) return abort_parse();
    if (c != ((fld_idx < FIELD_LAST) ? CH_MINUS : CH_RBRACE)) return abort_parse();
    case (fld_idx)
      FIELD_FIRST:  hi_acc = v << 32;
      FIELD_SECOND: hi_acc = hi_acc | (v << 16);
      FIELD_THIRD:  hi_acc = hi_acc | v;
      FIELD_FOURTH: lo_acc = v << 48;
      default: begin
        lo_acc  = lo_acc | v;
        fld_idx = FIELD_IDLE;
        reset_field();
        return ST_DONE;
      end
    endcase
    fld_idx = fld_idx + 3'd1;
    reset_field();
    return ST_BUSY;
  endfunction

  // whitespace and sign handling at the head of a field; 1 when consumed
  function automatic logic lead_char(input logic [15:0] c);
    if (is_blank(c)) begin
      phase = PH_SPACE;
      return 1'b1;
    end
    if (c == CH_MINUS) begin
      neg   = 1'b1;
      phase = PH_LEADMINUS;
      return 1'b1;
    end
    if (c == CH_PLUS) begin
      phase = PH_SIGN;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic status_t parse_char(input logic [15:0] c);
    logic [4:0] d;
    d = nibble_of(c);
    case (phase)
      PH_START: begin
        if (lead_char(c)) return ST_BUSY;
      end
      PH_SPACE: begin
        if (is_blank(c)) return ST_BUSY;
        if (c == CH_MINUS) begin
          neg   = 1'b1;
          phase = PH_SIGN;
          return ST_BUSY;
        end
        if (c == CH_PLUS) begin
          phase = PH_SIGN;
          return ST_BUSY;
        end
        if (d == NO_DIGIT) return abort_parse();
      end
      PH_LEADMINUS: begin
        // a lone minus is the separator of an empty field; c then opens the next one
        if (d == NO_DIGIT) begin
          if (fld_idx >= FIELD_LAST) return abort_parse();
          neg = 1'b0;
          if (finish_field(CH_MINUS) != ST_BUSY) return ST_ERR;
          if (lead_char(c)) return ST_BUSY;
        end
      end
      PH_SIGN: begin
        if (d == NO_DIGIT) return abort_parse();
      end
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          phase = PH_ZEROX;
          return ST_BUSY;
        end
        if (d == NO_DIGIT) return finish_field(c);
        shift_in(d[3:0]);
        phase = PH_DIGITS;
        return ST_BUSY;
      end
      PH_ZEROX: begin
        if (d == NO_DIGIT) return abort_parse();
        shift_in(d[3:0]);
        phase = PH_DIGITS;
        return ST_BUSY;
      end
      PH_DIGITS: begin
        if (d == NO_DIGIT) return finish_field(c);
        shift_in(d[3:0]);
        return ST_BUSY;
      end
      default: return abort_parse();
    endcase
    if (d == NO_DIGIT) return finish_field(c);
    if (d == 5'd0) begin
      phase = PH_ZERO;
      return ST_BUSY;
    end
    shift_in(d[3:0]);
    phase = PH_DIGITS;
    return ST_BUSY;
  endfunction

  function automatic guid_beat_t predict_status(input logic start, input logic [15:0] c);
    guid_beat_t r;
    status_t st;
    if (start) begin
      hi_acc = '0;
      lo_acc = '0;
      reset_field();
      if (c == CH_LBRACE) begin
        fld_idx = FIELD_FIRST;
        st = ST_BUSY;
      end else begin
        st = abort_parse();
      end
    end else if (fld_idx > FIELD_LAST) begin
      fld_idx = FIELD_IDLE;
      st = ST_IDLE;
    end else begin
      st = parse_char(c);
    end
    r.status = st;
    r.high   = (st == ST_DONE) ? hi_acc : '0;
    r.low    = (st == ST_DONE) ? lo_acc : '0;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] wanted);
    $display("[%0t] %s: got %h, expected %h", $realtime, what, got, wanted);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fld_idx = FIELD_IDLE;
      reset_field();
      hi_acc = '0;
      lo_acc = '0;
      mismatches = 0;
      status_q.delete();
    end else begin
      // check the outgoing beat before queueing the incoming one
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          note_mismatch("status beat with nothing pending", 64'(out_status), '0);
        end else begin
          want = status_q.pop_front();
          if (out_status != want.status)
            note_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_guid_high != want.high)
            note_mismatch("guid_high", out_guid_high, want.high);
          if (out_guid_low != want.low)
            note_mismatch("guid_low", out_guid_low, want.low);
        end
      end
      if (in_valid && in_ready)
        status_q.push_back(predict_status(in_start_req, in_char_code));
    end
    pending = status_q.size();
  end

endmodule

>>> test/guid_text_parser_tb.sv
module guid_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  logic        in_start_req;
  logic [15:0] in_char_code;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [63:0] out_guid_high;
  logic [63:0] out_guid_low;

  int mismatches;
  int pending;

  int          chars_sent = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          pressed = 1'b0;
  int          kind;
  int          pos;
  logic [15:0] chars[$];

  guid_text_parser DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_req  (in_start_req),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_guid_high (out_guid_high),
    .out_guid_low  (out_guid_low)
  );

  guid_text_parser_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_req  (in_start_req),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_guid_high (out_guid_high),
    .out_guid_low  (out_guid_low),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pause_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 16'(r);
  endfunction

  function automatic logic [15:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_DIGIT0 + 16'(n);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 16'(n) - 16'd10;
  endfunction

  // in_valid stays high from one beat to the next unless a gap is drawn
  task automatic send_char(input logic start, input logic [15:0] c);
    int gap;
    gap = pause_len(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(i == 0, 16'(s[i]));
  endtask

  task automatic send_line();
    foreach (chars[i]) send_char(i == 0, chars[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_field(input int k);
    int nib;
    int ndig;
    int mode;
    int fill;
    nib = (k == 0) ? 8 : (k == 4) ? 12 : 4;
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 2)) chars.push_back(blank_char());
    case ($urandom_range(0, 9))
      0, 1: chars.push_back(CH_MINUS);
      2:    chars.push_back(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      chars.push_back(CH_DIGIT0);
      chars.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
    end
    mode = $urandom_range(0, 19);
    fill = $urandom_range(0, 3);
    ndig = $urandom_range(1, nib);
    if (mode == 0) ndig = 0;
    else if (mode <= 4) ndig = nib;
    else if (mode == 5) begin
      // one past the field's largest value
      chars.push_back(hex_char(4'h1));
      ndig = nib;
      fill = 1;
    end else if (mode == 6) begin
      ndig = (k == 4) ? 17 : 9;
      fill = 0;
    end else if (mode == 7) begin
      repeat ($urandom_range(1, 3)) chars.push_back(CH_DIGIT0);
    end
    for (int i = 0; i < ndig; i++) begin
      if (fill == 0) chars.push_back(hex_char(4'hF));
      else if (fill == 1) chars.push_back(CH_DIGIT0);
      else chars.push_back(hex_char(4'($urandom_range(0, 15))));
    end
    if ($urandom_range(0, 29) == 0) chars.push_back(16'($urandom_range(0, 127)));
    else chars.push_back((k < 4) ? CH_MINUS : CH_RBRACE);
  endtask

  task automatic build_guid();
    chars.delete();
    chars.push_back(CH_LBRACE);
    for (int k = 0; k < 5; k++) put_field(k);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (1 + pause_len(1'b0)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    in_char_code = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle, bad opening, abort, empty fields, sign and prefix errors
    send_char(1'b0, 16'h8041);
    send_char(1'b1, 16'hFFFF);
    send_char(1'b0, 16'h0000);
    send_text("{7");
    send_text("{----}");
    send_char(1'b0, CH_RBRACE);
    send_text("{+-");
    send_text("{0x-");
    send_text("{\t}");
    drain();

    while (chars_sent < 735) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (!pressed && chars_sent > 250) begin
        // back-to-back beats against a stalled receiver
        pressed  = 1'b1;
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        build_guid();
        send_line();
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
          build_guid();
          send_line();
        end else if (kind < 86) begin
          build_guid();
          pos = $urandom_range(1, chars.size() - 1);
          if ($urandom_range(0, 1)) begin
            while (chars.size() > pos) void'(chars.pop_back());
          end else begin
            chars[pos] = 16'($urandom_range(0, 127));
          end
          send_line();
        end else begin
          repeat ($urandom_range(1, 6))
            send_char($urandom_range(0, 4) == 0, 16'($urandom_range(0, 16'hFFFF)));
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    in_valid <= 1'b0;
    repeat (5000) begin
      if (pending == 0) break;
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> guid_text_parser.f
design/gtp_pkg.sv
design/gtp_step.sv
design/guid_text_parser.sv
test/guid_text_parser_chk.sv
test/guid_text_parser_tb.sv
